>>> rtl/core/rcdd_pkg.sv
// Shared types and constants for the reflective sensor decay timer.
// No dependencies; imported by rcdd_core and rc_decay_reflect_debounce.
`default_nettype none

package rcdd_pkg;

   // Sensor timing, in ticks (one tick per microsecond)
   localparam int CHARGE_TICKS  = 10;
   localparam int TIMEOUT_TICKS = 3000;
   localparam int REST_MS       = 1;
   localparam int REST_TICKS    = REST_MS * 1000;

   localparam int TICK_W  = 12;
   localparam int RUN_W   = 17;
   localparam int THR_W   = 12;
   localparam int LIMIT_W = 16;
   localparam int CSR_W   = 16;

   localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(1000);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10);
   localparam logic [RUN_W-1:0]   RUN_MAX     = {RUN_W{1'b1}};

   // Register indexes
   localparam logic CSR_ON_THRESHOLD   = 1'b0;
   localparam logic CSR_DEBOUNCE_LIMIT = 1'b1;

   typedef enum logic [1:0] {
      MODE_TICK      = 2'd0,
      MODE_READ_RISE = 2'd1,
      MODE_READ_FALL = 2'd2,
      MODE_READ_RAW  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      PH_CHARGE = 3'b001,
      PH_DECAY  = 3'b010,
      PH_REST   = 3'b100
   } phase_type;

   typedef struct packed {
      mode_type mode;
      logic     pin_level;
   } req_type;

   typedef struct packed {
      logic              drive_high;
      logic              sample_done;
      logic [TICK_W-1:0] decay_time;
      logic              raw_reflect;
      logic              stable_level;
      logic              read_value;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/core/rc_decay_reflect_debounce.sv
// Results are registered, via the skid register when the output stalls.
// Throughput: one word per cycle unless stalled; the result register plus a
// one-word skid register let a request enter while a result waits downstream.
// Reset (synchronous, active high) returns to the charge phase, clears all
// measurement and debounce state, and loads threshold 1000 and limit 10.
// Top level: depends on rcdd_pkg and rcdd_core.
`default_nettype none

module rc_decay_reflect_debounce
   import rcdd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire req_type          req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      rsp_type          rsp_data,
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata
);

   rsp_type result;
   rsp_type out_ff;
   rsp_type skid_ff;
   logic    out_valid_ff;
   logic    skid_valid_ff;
   logic    accept;
   logic    out_free;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;

   rcdd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_word  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .result    (result)
   );

   // output register with skid word
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff  <= skid_valid_ff || accept;
         skid_valid_ff <= 1'b0;
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_valid_ff ? skid_ff : result;
      end
      if (!out_free && accept) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

>>> rtl/core/rcdd_core.sv
// Measurement state, debouncer and configuration registers of the decay timer.
// Depends on rcdd_pkg; produces the result word of the item accepted this cycle.
`default_nettype none

module rcdd_core
   import rcdd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire req_type           req_word,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [CSR_W-1:0]  csr_wdata,
   output rsp_type                result
);

   phase_type          phase_ff, phase_in;
   logic [TICK_W-1:0]  ticks_ff, ticks_in;
   logic [TICK_W-1:0]  decay_ff, decay_in;
   logic               raw_ff, raw_in;
   logic               deb_ff, deb_in;
   logic               primed_ff, primed_in;
   logic [RUN_W-1:0]   run_ff, run_in;
   logic               rise_ff, rise_in;
   logic               fall_ff, fall_in;
   logic [THR_W-1:0]   thr_ff;
   logic [LIMIT_W-1:0] limit_ff;

   logic [TICK_W:0]    ticks_inc;
   logic               finish;
   logic [TICK_W-1:0]  sample_t;
   logic               sample_raw;
   logic [RUN_W-1:0]   run_sat;
   logic               drive;
   logic               read_val;

   assign ticks_inc = {1'b0, ticks_ff} + (TICK_W+1)'(1);
   assign drive     = (phase_ff != PH_DECAY) && (phase_ff != PH_REST);
   // decay ends when the pin falls or the timeout is hit
   assign finish    = (req_word.mode == MODE_TICK) && (phase_ff == PH_DECAY) &&
                      (!req_word.pin_level || (ticks_inc >= (TICK_W+1)'(TIMEOUT_TICKS)));
   assign sample_t   = req_word.pin_level ? TICK_W'(TIMEOUT_TICKS) : ticks_ff;
   assign sample_raw = (sample_t <= thr_ff);
   assign run_sat    = (run_ff == RUN_MAX) ? run_ff : run_ff + RUN_W'(1);

   // next state for one item
   always_comb begin
      phase_in  = phase_ff;
      ticks_in  = ticks_ff;
      decay_in  = decay_ff;
      raw_in    = raw_ff;
      deb_in    = deb_ff;
      primed_in = primed_ff;
      run_in    = run_ff;
      rise_in   = rise_ff;
      fall_in   = fall_ff;
      read_val  = 1'b0;

      unique case (req_word.mode)
         MODE_TICK: begin
            unique case (phase_ff)
               PH_DECAY: begin
                  ticks_in = ticks_inc[TICK_W-1:0];
               end
               PH_REST: begin
                  if (ticks_inc >= (TICK_W+1)'(REST_TICKS)) begin
                     phase_in = PH_CHARGE;
                     ticks_in = '0;
                  end else begin
                     ticks_in = ticks_inc[TICK_W-1:0];
                  end
               end
               default: begin
                  // charge, also recovers any unused code
                  if (ticks_inc >= (TICK_W+1)'(CHARGE_TICKS)) begin
                     phase_in = PH_DECAY;
                     ticks_in = '0;
                  end else begin
                     phase_in = PH_CHARGE;
                     ticks_in = ticks_inc[TICK_W-1:0];
                  end
               end
            endcase
         end
         MODE_READ_RISE: begin
            read_val = rise_ff;
            rise_in  = 1'b0;
         end
         MODE_READ_FALL: begin
            read_val = fall_ff;
            fall_in  = 1'b0;
         end
         MODE_READ_RAW: begin
            read_val = raw_ff;
         end
      endcase

      // completed measurement: record and debounce
      if (finish) begin
         decay_in = sample_t;
         raw_in   = sample_raw;
         ticks_in = '0;
         phase_in = (REST_TICKS == 0) ? PH_CHARGE : PH_REST;
         if (!primed_ff) begin
            deb_in    = sample_raw;
            primed_in = 1'b1;
            run_in    = '0;
         end else if (sample_raw != deb_ff) begin
            run_in = run_sat;
            if (run_sat > {1'b0, limit_ff}) begin
               if (deb_ff) fall_in = 1'b1;
               else        rise_in = 1'b1;
               deb_in = sample_raw;
            end
         end else begin
            run_in = '0;
         end
      end
   end

   // result reflects state after the item, but drive_high and read_value before it
   always_comb begin
      result.drive_high   = drive;
      result.sample_done  = finish;
      result.decay_time   = decay_in;
      result.raw_reflect  = raw_in;
      result.stable_level = deb_in;
      result.read_value   = read_val;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_CHARGE;
         ticks_ff  <= '0;
         decay_ff  <= '0;
         raw_ff    <= 1'b0;
         deb_ff    <= 1'b0;
         primed_ff <= 1'b0;
         run_ff    <= '0;
         rise_ff   <= 1'b0;
         fall_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         ticks_ff  <= ticks_in;
         decay_ff  <= decay_in;
         raw_ff    <= raw_in;
         deb_ff    <= deb_in;
         primed_ff <= primed_in;
         run_ff    <= run_in;
         rise_ff   <= rise_in;
         fall_ff   <= fall_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= THR_RESET;
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ON_THRESHOLD:   thr_ff   <= csr_wdata[THR_W-1:0];
            CSR_DEBOUNCE_LIMIT: limit_ff <= csr_wdata[LIMIT_W-1:0];
         endcase
      end
   end

endmodule

`default_nettype wire
